// ===== sv/per_source_token_bucket_limiter_unit_macros.svh =====
// assertion macros for the per-source token bucket limiter
`ifndef PER_SOURCE_TOKEN_BUCKET_LIMITER_UNIT_MACROS_SVH
`define PER_SOURCE_TOKEN_BUCKET_LIMITER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define PSTBL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pstbl assertion failed");
// property checked on every edge
`define PSTBL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pstbl assertion failed");
`else
`define PSTBL_ASSERT(name, clk, rst_n, prop)
`define PSTBL_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== sv/pstbl_pkg.sv =====
// shared types and constants of the per-source token bucket limiter
package pstbl_pkg;

  // field widths
  localparam int ADDR_W = 32;
  localparam int TIME_W = 64;
  localparam int RATE_W = 24;
  localparam int TOK_W  = 54;
  localparam int ELAP_W = 36;
  localparam int PROD_W = 60;
  localparam int SUM_W  = 61;

  // token scale and refill cap
  localparam logic [29:0]       TOKENS_PER_PKT = 30'd1000000000;
  localparam logic [ELAP_W-1:0] MAX_ELAPSED_NS = 36'd60000000000;

  // operation codes
  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_INSTALL = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_RULE = 2'd2;

  // search token travelling down the cell row
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic              match_hit;
    logic              free_hit;
  } srch_t;

  // rule update broadcast to the cells
  typedef struct packed {
    logic              we;
    logic              valid;
    logic [ADDR_W-1:0] source;
  } cam_wr_t;

  // per-rule bucket record
  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last_time;
    logic [RATE_W-1:0] rate;
  } bkt_t;

endpackage

// ===== sv/pstbl_cell.sv =====
// one rule cell: holds a key and passes the search token to its neighbour
module pstbl_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pstbl_pkg::srch_t   srch_in,
  input  logic [IDX_W-1:0]   match_idx_in,
  input  logic [IDX_W-1:0]   free_idx_in,
  output pstbl_pkg::srch_t   srch_out,
  output logic [IDX_W-1:0]   match_idx_out,
  output logic [IDX_W-1:0]   free_idx_out,
  input  pstbl_pkg::cam_wr_t wr,
  input  logic [IDX_W-1:0]   wr_idx
);
  import pstbl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic              valid_r;
  logic [ADDR_W-1:0] source_r;
  srch_t             srch_r, srch_nxt;
  logic [IDX_W-1:0]  match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic              hit;

  // key compare and first-hit tracking
  always_comb begin
    hit           = valid_r && (source_r == srch_in.addr);
    srch_nxt      = srch_in;
    match_idx_nxt = match_idx_in;
    free_idx_nxt  = free_idx_in;
    if (hit && !srch_in.match_hit) begin
      match_idx_nxt = MY_IDX;
    end
    if (!valid_r && !srch_in.free_hit) begin
      free_idx_nxt = MY_IDX;
    end
    srch_nxt.match_hit = srch_in.match_hit || hit;
    srch_nxt.free_hit  = srch_in.free_hit || !valid_r;
  end

  // rule storage and search stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      srch_r  <= '0;
    end else begin
      srch_r <= srch_nxt;
      if (wr.we && (wr_idx == MY_IDX)) begin
        valid_r <= wr.valid;
      end
    end
    if (wr.we && wr.valid && (wr_idx == MY_IDX)) begin
      source_r <= wr.source;
    end
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
  end

  assign srch_out      = srch_r;
  assign match_idx_out = match_idx_r;
  assign free_idx_out  = free_idx_r;

endmodule

// ===== sv/pstbl_store.sv =====
// bucket record memory: one write port, one registered read port
module pstbl_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  pstbl_pkg::bkt_t     wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output pstbl_pkg::bkt_t     rd_data
);
  import pstbl_pkg::*;

  bkt_t mem [0:DEPTH-1];
  bkt_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/per_source_token_bucket_limiter_unit.sv =====
// top level of the per-source token bucket limiter
//
// The in_ channel carries one item per transfer: in_tuser is the operation
// (check packet, install rule, remove rule), in_tdata the source address,
// the nanosecond timestamp and the install rate. Every item gives exactly one
// transfer on the out_ channel: allowed, rule_found and status.
// Items are handled one at a time. The search token walks the row of ENTRIES
// rule cells, one cell per cycle; a miss, remove, full install or unused op
// then gives its result, an install with a rule or free cell first forms the
// capacity product, and a check that hits a rule goes through bucket read,
// elapsed time, the two multiplies, refill and clamp, spend and write back.
// The next item can be taken once the result is loaded and the unit is idle.
// The result sits in an output register: a stalled receiver does not stop the
// next item from being accepted, but that item waits in its last step until
// the register is free.
// Reset clears all rule valid bits and the handshake state; bucket records
// are written by install before they are read, so they need no clearing.
`include "per_source_token_bucket_limiter_unit_macros.svh"

module per_source_token_bucket_limiter_unit #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // op
  input  logic [119:0] in_tdata,   // source_address, now_ns, rate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // allowed, rule_found, status, zero fill
);
  import pstbl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_ELAP, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t            state_r;
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TIME_W-1:0] now_r;
  logic [RATE_W-1:0] rate_in_r;
  logic              hit_r, free_r;
  logic [IDX_W-1:0]  tgt_idx_r;
  logic [RATE_W-1:0] rate_r;
  logic [TOK_W-1:0]  tok_r;
  logic [ELAP_W-1:0] elap_r;
  logic [TOK_W-1:0]  cap_r;
  logic [PROD_W-1:0] prod_r;
  logic [TOK_W-1:0]  tok_new_r;
  logic              out_tvalid_r;
  logic [7:0]        out_tdata_r;

  srch_t             link      [0:ENTRIES];
  logic [IDX_W-1:0]  match_idx [0:ENTRIES];
  logic [IDX_W-1:0]  free_idx  [0:ENTRIES];
  cam_wr_t           cam_wr;

  logic              in_fire, done_fire;
  logic              mem_we, mem_re;
  bkt_t              mem_wdata, mem_rdata;
  logic [TIME_W-1:0] diff;
  logic [ELAP_W-1:0] elap_nxt;
  logic [RATE_W-1:0] rate_sel;
  logic [TOK_W-1:0]  cap_nxt;
  logic [PROD_W-1:0] prod_nxt;
  logic [SUM_W-1:0]  sum;
  logic [TOK_W-1:0]  tok_clamp;
  logic              spend_ok;
  logic [TOK_W-1:0]  tok_left;
  logic              res_allowed, res_found;
  logic [1:0]        res_status;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign done_fire = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // search token enters the cell row on acceptance
  assign link[0]      = '{vld: in_fire, addr: in_tdata[31:0], match_hit: 1'b0,
                          free_hit: 1'b0};
  assign match_idx[0] = '0;
  assign free_idx[0]  = '0;

  // row of rule cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pstbl_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .srch_in       (link[g]),
      .match_idx_in  (match_idx[g]),
      .free_idx_in   (free_idx[g]),
      .srch_out      (link[g+1]),
      .match_idx_out (match_idx[g+1]),
      .free_idx_out  (free_idx[g+1]),
      .wr            (cam_wr),
      .wr_idx        (tgt_idx_r)
    );
  end

  // bucket record memory
  assign mem_re = (state_r == S_SEARCH) && link[ENTRIES].vld;

  pstbl_store #(
    .DEPTH (ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (tgt_idx_r),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (match_idx[ENTRIES]),
    .rd_data (mem_rdata)
  );

  // elapsed time, wrapped and capped
  assign diff     = now_r - mem_rdata.last_time;
  assign elap_nxt = (diff > TIME_W'(MAX_ELAPSED_NS)) ? MAX_ELAPSED_NS : diff[ELAP_W-1:0];

  // capacity and refill products
  assign rate_sel = (op_r == OP_INSTALL) ? rate_in_r : rate_r;
  assign cap_nxt  = TOK_W'(rate_sel) * TOK_W'(TOKENS_PER_PKT);
  assign prod_nxt = PROD_W'(rate_r) * PROD_W'(elap_r);

  // refill and clamp to capacity
  assign sum       = SUM_W'(tok_r) + SUM_W'(prod_r);
  assign tok_clamp = (sum > SUM_W'(cap_r)) ? cap_r : sum[TOK_W-1:0];

  // spend one packet's worth
  assign spend_ok = (tok_new_r >= TOK_W'(TOKENS_PER_PKT));
  assign tok_left = spend_ok ? (tok_new_r - TOK_W'(TOKENS_PER_PKT)) : tok_new_r;

  // result and state updates of the finishing item
  always_comb begin
    res_allowed = 1'b1;
    res_found   = 1'b0;
    res_status  = ST_DONE;
    mem_we      = 1'b0;
    mem_wdata   = '{tokens: cap_r, last_time: now_r, rate: rate_in_r};
    cam_wr      = '{we: 1'b0, valid: 1'b0, source: addr_r};
    unique case (op_r)
      OP_CHECK: begin
        res_found = hit_r;
        if (hit_r) begin
          res_allowed = spend_ok;
          mem_we      = done_fire;
          mem_wdata   = '{tokens: tok_left, last_time: now_r, rate: rate_r};
        end
      end
      OP_INSTALL: begin
        res_found = hit_r;
        if (hit_r || free_r) begin
          mem_we       = done_fire;
          cam_wr.we    = done_fire;
          cam_wr.valid = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        res_found = hit_r;
        if (hit_r) begin
          cam_wr.we = done_fire;
        end else begin
          res_status = ST_NO_RULE;
        end
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // output valid: load on a finishing item, clear on transfer
      if (done_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r      <= in_tuser;
            addr_r    <= in_tdata[31:0];
            now_r     <= in_tdata[95:32];
            rate_in_r <= in_tdata[119:96];
            state_r   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (link[ENTRIES].vld) begin
            hit_r     <= link[ENTRIES].match_hit;
            free_r    <= link[ENTRIES].free_hit;
            tgt_idx_r <= link[ENTRIES].match_hit ? match_idx[ENTRIES]
                                                 : free_idx[ENTRIES];
            if (op_r == OP_CHECK && link[ENTRIES].match_hit) begin
              state_r <= S_ELAP;
            end else if (op_r == OP_INSTALL &&
                         (link[ENTRIES].match_hit || link[ENTRIES].free_hit)) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_ELAP: begin
          elap_r  <= elap_nxt;
          rate_r  <= mem_rdata.rate;
          tok_r   <= mem_rdata.tokens;
          state_r <= S_MUL;
        end
        S_MUL: begin
          cap_r   <= cap_nxt;
          prod_r  <= prod_nxt;
          state_r <= (op_r == OP_CHECK) ? S_ADD : S_DONE;
        end
        S_ADD: begin
          tok_new_r <= tok_clamp;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            out_tdata_r <= {4'd0, res_status, res_found, res_allowed};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `PSTBL_ASSERT(a_search_window, clk, rst_n, link[ENTRIES].vld |-> state_r == S_SEARCH)
  `PSTBL_ASSERT(a_accept_starts_search, clk, rst_n, in_fire |=> state_r == S_SEARCH)
  `PSTBL_ASSERT(a_result_from_done, clk, rst_n, $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
  `PSTBL_ASSERT(a_single_write, clk, rst_n, (mem_we || cam_wr.we) |-> done_fire)

endmodule
